FILE: sv/crtc_mode_line_validator_defines.svh
// ---------------------------------------------------------------------------
// CRTC mode line validator assertion macros
// Assertion helpers for the validator; they compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef CRTC_MODE_LINE_VALIDATOR_DEFINES_SVH
`define CRTC_MODE_LINE_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define CRTC_MLV_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication, checked outside reset
`define CRTC_MLV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define CRTC_MLV_ASSERT_IMPL(label, ante, cons)
`define CRTC_MLV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/crtc_mlv_pkg.sv
// ---------------------------------------------------------------------------
// CRTC mode line validator package
// Shared types and timing limits for the mode line validator.
// ---------------------------------------------------------------------------
package crtc_mlv_pkg;

   // horizontal limits
   localparam logic [12:0] HDISP_MASK   = 13'h07F8;
   localparam logic [12:0] HPOS_MASK    = 13'h0FF8;
   localparam logic [12:0] HDISP_MIN    = 13'd640;
   localparam logic [12:0] HDISP_MAX    = 13'd2048;
   localparam logic [12:0] HBLANK_MIN   = 13'd80;
   localparam logic [12:0] HSYNC_GAP    = 13'd8;
   localparam logic [12:0] HSYNC_MAX    = 13'h00F8;

   // vertical limits
   localparam logic [12:0] VDISP_MASK   = 13'h07FF;
   localparam logic [12:0] VPOS_MASK    = 13'h0FFF;
   localparam logic [12:0] VDISP_MIN    = 13'd400;
   localparam logic [12:0] VDISP_MAX    = 13'd2048;
   localparam logic [12:0] VBLANK_MIN   = 13'd3;
   localparam logic [12:0] VSYNC_GAP    = 13'd1;
   localparam logic [12:0] VSYNC_MAX    = 13'h000F;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_H_FAIL = 2'd1,
      STATUS_V_FAIL = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] hdisp_end;
      logic [15:0] hsync_start;
      logic [15:0] hsync_end;
      logic [15:0] htotal;
      logic [15:0] vdisp_end;
      logic [15:0] vsync_start;
      logic [15:0] vsync_end;
      logic [15:0] vtotal;
   } mode_line_type;

   typedef struct packed {
      logic [11:0] hdisp_end;
      logic [11:0] hsync_start;
      logic [11:0] hsync_end;
      logic [11:0] htotal;
      logic [15:0] vdisp_end;
      logic [15:0] vsync_start;
      logic [15:0] vsync_end;
      logic [15:0] vtotal;
      status_type  status;
   } result_type;

endpackage

FILE: sv/crtc_mode_line_validator.sv
// An accepted request passes the input register and then the result register
// before its result shows on the rsp_ ports.
// Throughput: one request per cycle; busy is never raised.
// The result strobe rsp_valid lasts one cycle and the receiver cannot stall.
// Reset (synchronous, active high) clears both valid flags; no result is
// in flight afterwards.
// ---------------------------------------------------------------------------
// CRTC mode line validator
// Registers a raw mode line, corrects it and registers the result.
// ---------------------------------------------------------------------------
`include "crtc_mode_line_validator_defines.svh"

module crtc_mode_line_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_raw_hdisp_end,
   input  logic [15:0] req_raw_hsync_start,
   input  logic [15:0] req_raw_hsync_end,
   input  logic [15:0] req_raw_htotal,
   input  logic [15:0] req_raw_vdisp_end,
   input  logic [15:0] req_raw_vsync_start,
   input  logic [15:0] req_raw_vsync_end,
   input  logic [15:0] req_raw_vtotal,
   output logic        rsp_valid,
   output logic [11:0] rsp_hdisp_end,
   output logic [11:0] rsp_hsync_start,
   output logic [11:0] rsp_hsync_end,
   output logic [11:0] rsp_htotal,
   output logic [15:0] rsp_vdisp_end,
   output logic [15:0] rsp_vsync_start,
   output logic [15:0] rsp_vsync_end,
   output logic [15:0] rsp_vtotal,
   output logic [1:0]  rsp_status
);

   logic                        req_accept;
   logic                        stage_valid_ff;
   crtc_mlv_pkg::mode_line_type stage_ff;
   crtc_mlv_pkg::mode_line_type stage_in;
   crtc_mlv_pkg::result_type    result_in;
   crtc_mlv_pkg::result_type    result_ff;
   logic                        rsp_valid_ff;

   // never stall the request side
   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   assign stage_in.hdisp_end   = req_raw_hdisp_end;
   assign stage_in.hsync_start = req_raw_hsync_start;
   assign stage_in.hsync_end   = req_raw_hsync_end;
   assign stage_in.htotal      = req_raw_htotal;
   assign stage_in.vdisp_end   = req_raw_vdisp_end;
   assign stage_in.vsync_start = req_raw_vsync_start;
   assign stage_in.vsync_end   = req_raw_vsync_end;
   assign stage_in.vtotal      = req_raw_vtotal;

   // valid flags advance every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= req_accept;
         rsp_valid_ff   <= stage_valid_ff;
      end
   end

   // capture the request payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
   end

   crtc_mlv_core u_core (
      .raw    (stage_ff),
      .result (result_in)
   );

   // hold the corrected mode line for its strobe cycle
   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hdisp_end   = result_ff.hdisp_end;
   assign rsp_hsync_start = result_ff.hsync_start;
   assign rsp_hsync_end   = result_ff.hsync_end;
   assign rsp_htotal      = result_ff.htotal;
   assign rsp_vdisp_end   = result_ff.vdisp_end;
   assign rsp_vsync_start = result_ff.vsync_start;
   assign rsp_vsync_end   = result_ff.vsync_end;
   assign rsp_vtotal      = result_ff.vtotal;
   assign rsp_status      = result_ff.status;

   `CRTC_MLV_ASSERT_NEXT(a_stage_to_rsp, stage_valid_ff, rsp_valid)
   `CRTC_MLV_ASSERT_NEXT(a_no_spurious_rsp, !stage_valid_ff, !rsp_valid)
   `CRTC_MLV_ASSERT_IMPL(a_hblank_kept, rsp_valid, rsp_htotal >= rsp_hdisp_end + 12'd80)
   `CRTC_MLV_ASSERT_IMPL(a_hsync_in_total, rsp_valid, rsp_hsync_end < rsp_htotal)
   `CRTC_MLV_ASSERT_IMPL(a_vdisp_min,
      rsp_valid && rsp_status == crtc_mlv_pkg::STATUS_OK, rsp_vdisp_end >= 16'd400)

endmodule

FILE: sv/crtc_mlv_core.sv
// ---------------------------------------------------------------------------
// CRTC mode line correction logic
// Masks, clamps and orders one raw mode line and flags out-of-range results.
// ---------------------------------------------------------------------------
module crtc_mlv_core (
   input  crtc_mlv_pkg::mode_line_type raw,
   output crtc_mlv_pkg::result_type    result
);

   always_comb begin
      logic [12:0] hd;
      logic [12:0] hss;
      logic [12:0] hse;
      logic [12:0] ht;
      logic [12:0] vd;
      logic [12:0] vss;
      logic [12:0] vse;
      logic [12:0] vt;
      logic        h_fail;
      logic        v_fail;

      // mask horizontal values to multiples of 8
      hd  = raw.hdisp_end[12:0]   & crtc_mlv_pkg::HDISP_MASK;
      hss = raw.hsync_start[12:0] & crtc_mlv_pkg::HPOS_MASK;
      hse = raw.hsync_end[12:0]   & crtc_mlv_pkg::HPOS_MASK;
      ht  = raw.htotal[12:0]      & crtc_mlv_pkg::HPOS_MASK;

      // clamp display end, then order total and sync around it
      if (hd < crtc_mlv_pkg::HDISP_MIN) hd = crtc_mlv_pkg::HDISP_MIN;
      if (hd > crtc_mlv_pkg::HDISP_MAX) hd = crtc_mlv_pkg::HDISP_MAX;
      if (ht < hd + crtc_mlv_pkg::HBLANK_MIN) ht = hd + crtc_mlv_pkg::HBLANK_MIN;
      if (hse > ht - crtc_mlv_pkg::HSYNC_GAP) hse = ht - crtc_mlv_pkg::HSYNC_GAP;
      if (hss < hd + crtc_mlv_pkg::HSYNC_GAP) hss = hd + crtc_mlv_pkg::HSYNC_GAP;
      if (hse > hss + crtc_mlv_pkg::HSYNC_MAX) hse = hss + crtc_mlv_pkg::HSYNC_MAX;

      h_fail = (hd  != (hd  & crtc_mlv_pkg::HDISP_MASK)) ||
               (hss != (hss & crtc_mlv_pkg::HPOS_MASK))  ||
               (hse != (hse & crtc_mlv_pkg::HPOS_MASK))  ||
               (ht  != (ht  & crtc_mlv_pkg::HPOS_MASK));

      // same treatment for the vertical values, masked without alignment to multiples of 8
      vd  = raw.vdisp_end[12:0]   & crtc_mlv_pkg::VDISP_MASK;
      vss = raw.vsync_start[12:0] & crtc_mlv_pkg::VPOS_MASK;
      vse = raw.vsync_end[12:0]   & crtc_mlv_pkg::VPOS_MASK;
      vt  = raw.vtotal[12:0]      & crtc_mlv_pkg::VPOS_MASK;

      if (vd < crtc_mlv_pkg::VDISP_MIN) vd = crtc_mlv_pkg::VDISP_MIN;
      if (vd > crtc_mlv_pkg::VDISP_MAX) vd = crtc_mlv_pkg::VDISP_MAX;
      if (vt < vd + crtc_mlv_pkg::VBLANK_MIN) vt = vd + crtc_mlv_pkg::VBLANK_MIN;
      if (vse > vt - crtc_mlv_pkg::VSYNC_GAP) vse = vt - crtc_mlv_pkg::VSYNC_GAP;
      if (vss < vd + crtc_mlv_pkg::VSYNC_GAP) vss = vd + crtc_mlv_pkg::VSYNC_GAP;
      if (vse > vss + crtc_mlv_pkg::VSYNC_MAX) vse = vss + crtc_mlv_pkg::VSYNC_MAX;

      v_fail = (vd  != (vd  & crtc_mlv_pkg::VDISP_MASK)) ||
               (vss != (vss & crtc_mlv_pkg::VPOS_MASK))  ||
               (vse != (vse & crtc_mlv_pkg::VPOS_MASK))  ||
               (vt  != (vt  & crtc_mlv_pkg::VPOS_MASK));

      // horizontal fields always carry the corrected values
      result.hdisp_end   = hd[11:0];
      result.hsync_start = hss[11:0];
      result.hsync_end   = hse[11:0];
      result.htotal      = ht[11:0];

      // pass raw vertical values through on a horizontal failure
      if (h_fail) begin
         result.vdisp_end   = raw.vdisp_end;
         result.vsync_start = raw.vsync_start;
         result.vsync_end   = raw.vsync_end;
         result.vtotal      = raw.vtotal;
         result.status      = crtc_mlv_pkg::STATUS_H_FAIL;
      end else begin
         result.vdisp_end   = {3'b000, vd};
         result.vsync_start = {3'b000, vss};
         result.vsync_end   = {3'b000, vse};
         result.vtotal      = {3'b000, vt};
         result.status      = v_fail ? crtc_mlv_pkg::STATUS_V_FAIL
                                     : crtc_mlv_pkg::STATUS_OK;
      end
   end

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// CRTC mode line validator testbench
// Drives raw mode lines through the start/busy command port, predicts each
// corrected line (masking, clamps, sync placement and status) in the bench
// or takes a typed-in one, and compares every strobed result field by field
// in request order. A short table of directed lines comes first, then random
// lines, mostly plausible timings and some raw noise, with random sender gaps.
// ---------------------------------------------------------------------------
module testbench;

   localparam int unsigned RANDOM_LINES = 850;
   localparam int unsigned CALM_TAIL    = 100;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned CYCLE_LIMIT  = 60000;
   localparam int unsigned ROW_COUNT    = 16;

   typedef struct {
      crtc_mlv_pkg::mode_line_type line;
      bit                          golden_known;
      crtc_mlv_pkg::result_type    golden;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_raw_hdisp_end;
   logic [15:0] req_raw_hsync_start;
   logic [15:0] req_raw_hsync_end;
   logic [15:0] req_raw_htotal;
   logic [15:0] req_raw_vdisp_end;
   logic [15:0] req_raw_vsync_start;
   logic [15:0] req_raw_vsync_end;
   logic [15:0] req_raw_vtotal;
   logic        rsp_valid;
   logic [11:0] rsp_hdisp_end;
   logic [11:0] rsp_hsync_start;
   logic [11:0] rsp_hsync_end;
   logic [11:0] rsp_htotal;
   logic [15:0] rsp_vdisp_end;
   logic [15:0] rsp_vsync_start;
   logic [15:0] rsp_vsync_end;
   logic [15:0] rsp_vtotal;
   logic [1:0]  rsp_status;

   // typed-in expectation that travels with the request on the port
   logic                     golden_known;
   crtc_mlv_pkg::result_type golden_line;

   crtc_mlv_pkg::result_type expected_lines[$];
   int unsigned              failures;
   int unsigned              lines_sent;
   int unsigned              lines_checked;
   int unsigned              cycle_count;
   stim_row_type             directed_rows [0:ROW_COUNT-1];

   crtc_mode_line_validator DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_raw_hdisp_end   (req_raw_hdisp_end),
      .req_raw_hsync_start (req_raw_hsync_start),
      .req_raw_hsync_end   (req_raw_hsync_end),
      .req_raw_htotal      (req_raw_htotal),
      .req_raw_vdisp_end   (req_raw_vdisp_end),
      .req_raw_vsync_start (req_raw_vsync_start),
      .req_raw_vsync_end   (req_raw_vsync_end),
      .req_raw_vtotal      (req_raw_vtotal),
      .rsp_valid           (rsp_valid),
      .rsp_hdisp_end       (rsp_hdisp_end),
      .rsp_hsync_start     (rsp_hsync_start),
      .rsp_hsync_end       (rsp_hsync_end),
      .rsp_htotal          (rsp_htotal),
      .rsp_vdisp_end       (rsp_vdisp_end),
      .rsp_vsync_start     (rsp_vsync_start),
      .rsp_vsync_end       (rsp_vsync_end),
      .rsp_vtotal          (rsp_vtotal),
      .rsp_status          (rsp_status)
   );

   // 4 unit period clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Correct one raw mode line the way the block should.
   function automatic crtc_mlv_pkg::result_type correct_mode_line(
      input crtc_mlv_pkg::mode_line_type raw);
      logic [12:0]              hd, hss, hse, ht;
      logic [12:0]              vd, vss, vse, vt;
      crtc_mlv_pkg::result_type fixed;
      hd  = raw.hdisp_end[12:0]   & crtc_mlv_pkg::HDISP_MASK;
      hss = raw.hsync_start[12:0] & crtc_mlv_pkg::HPOS_MASK;
      hse = raw.hsync_end[12:0]   & crtc_mlv_pkg::HPOS_MASK;
      ht  = raw.htotal[12:0]      & crtc_mlv_pkg::HPOS_MASK;

      // clamp width, leave blanking, then place the sync pulse
      if (hd < crtc_mlv_pkg::HDISP_MIN) hd = crtc_mlv_pkg::HDISP_MIN;
      if (hd > crtc_mlv_pkg::HDISP_MAX) hd = crtc_mlv_pkg::HDISP_MAX;
      if (ht < hd + crtc_mlv_pkg::HBLANK_MIN) ht = hd + crtc_mlv_pkg::HBLANK_MIN;
      if (hse > ht - crtc_mlv_pkg::HSYNC_GAP) hse = ht - crtc_mlv_pkg::HSYNC_GAP;
      if (hss < hd + crtc_mlv_pkg::HSYNC_GAP) hss = hd + crtc_mlv_pkg::HSYNC_GAP;
      if (hse > hss + crtc_mlv_pkg::HSYNC_MAX) hse = hss + crtc_mlv_pkg::HSYNC_MAX;

      fixed.hdisp_end   = hd[11:0];
      fixed.hsync_start = hss[11:0];
      fixed.hsync_end   = hse[11:0];
      fixed.htotal      = ht[11:0];
      fixed.status      = crtc_mlv_pkg::STATUS_OK;

      if (hd != (hd & crtc_mlv_pkg::HDISP_MASK) || hss != (hss & crtc_mlv_pkg::HPOS_MASK) ||
          hse != (hse & crtc_mlv_pkg::HPOS_MASK) || ht != (ht & crtc_mlv_pkg::HPOS_MASK)) begin
         // horizontal overflow: pass the vertical values through untouched
         fixed.status      = crtc_mlv_pkg::STATUS_H_FAIL;
         fixed.vdisp_end   = raw.vdisp_end;
         fixed.vsync_start = raw.vsync_start;
         fixed.vsync_end   = raw.vsync_end;
         fixed.vtotal      = raw.vtotal;
      end else begin
         vd  = raw.vdisp_end[12:0]   & crtc_mlv_pkg::VDISP_MASK;
         vss = raw.vsync_start[12:0] & crtc_mlv_pkg::VPOS_MASK;
         vse = raw.vsync_end[12:0]   & crtc_mlv_pkg::VPOS_MASK;
         vt  = raw.vtotal[12:0]      & crtc_mlv_pkg::VPOS_MASK;

         if (vd < crtc_mlv_pkg::VDISP_MIN) vd = crtc_mlv_pkg::VDISP_MIN;
         if (vd > crtc_mlv_pkg::VDISP_MAX) vd = crtc_mlv_pkg::VDISP_MAX;
         if (vt < vd + crtc_mlv_pkg::VBLANK_MIN) vt = vd + crtc_mlv_pkg::VBLANK_MIN;
         if (vse > vt - crtc_mlv_pkg::VSYNC_GAP) vse = vt - crtc_mlv_pkg::VSYNC_GAP;
         if (vss < vd + crtc_mlv_pkg::VSYNC_GAP) vss = vd + crtc_mlv_pkg::VSYNC_GAP;
         if (vse > vss + crtc_mlv_pkg::VSYNC_MAX) vse = vss + crtc_mlv_pkg::VSYNC_MAX;

         if (vd != (vd & crtc_mlv_pkg::VDISP_MASK) || vss != (vss & crtc_mlv_pkg::VPOS_MASK) ||
             vse != (vse & crtc_mlv_pkg::VPOS_MASK) || vt != (vt & crtc_mlv_pkg::VPOS_MASK))
            fixed.status = crtc_mlv_pkg::STATUS_V_FAIL;

         fixed.vdisp_end   = {3'b000, vd};
         fixed.vsync_start = {3'b000, vss};
         fixed.vsync_end   = {3'b000, vse};
         fixed.vtotal      = {3'b000, vt};
      end
      return fixed;
   endfunction

   // Mostly plausible timings with random content, some raw noise.
   function automatic crtc_mlv_pkg::mode_line_type random_mode_line();
      crtc_mlv_pkg::mode_line_type line;
      int unsigned                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         line = {$urandom, $urandom, $urandom, $urandom};
      end else begin
         line.hdisp_end   = 16'($urandom_range(0, 2200));
         line.hsync_start = line.hdisp_end + 16'($urandom_range(0, 320)) - 16'd16;
         line.hsync_end   = line.hsync_start + 16'($urandom_range(0, 400));
         line.htotal      = line.hsync_end + 16'($urandom_range(0, 600)) - 16'd100;
         line.vdisp_end   = 16'($urandom_range(300, 2100));
         line.vsync_start = line.vdisp_end + 16'($urandom_range(0, 8)) - 16'd2;
         line.vsync_end   = line.vsync_start + 16'($urandom_range(0, 24));
         line.vtotal      = line.vsync_end + 16'($urandom_range(0, 60)) - 16'd10;
         // stray bits above the masks
         if (pick >= 85)
            line = line | ({$urandom, $urandom, $urandom, $urandom} & {8{16'hF000}});
      end
      return line;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(input crtc_mlv_pkg::mode_line_type line, input bit known,
                               input crtc_mlv_pkg::result_type golden);
      req_raw_hdisp_end   <= line.hdisp_end;
      req_raw_hsync_start <= line.hsync_start;
      req_raw_hsync_end   <= line.hsync_end;
      req_raw_htotal      <= line.htotal;
      req_raw_vdisp_end   <= line.vdisp_end;
      req_raw_vsync_start <= line.vsync_start;
      req_raw_vsync_end   <= line.vsync_end;
      req_raw_vtotal      <= line.vtotal;
      golden_known        <= known;
      golden_line         <= golden;
      start               <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      lines_sent++;
   endtask

   // Drop start for a number of cycles.
   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Compare each strobed result, then queue the prediction for a new request.
   always @(posedge clock) begin : result_monitor
      crtc_mlv_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_lines.size() == 0) begin
               $error("result strobe with no request outstanding");
               failures++;
            end else begin
               want = expected_lines.pop_front();
               lines_checked++;
               check_field("hdisp_end",   16'(want.hdisp_end),   16'(rsp_hdisp_end));
               check_field("hsync_start", 16'(want.hsync_start), 16'(rsp_hsync_start));
               check_field("hsync_end",   16'(want.hsync_end),   16'(rsp_hsync_end));
               check_field("htotal",      16'(want.htotal),      16'(rsp_htotal));
               check_field("vdisp_end",   want.vdisp_end,        rsp_vdisp_end);
               check_field("vsync_start", want.vsync_start,      rsp_vsync_start);
               check_field("vsync_end",   want.vsync_end,        rsp_vsync_end);
               check_field("vtotal",      want.vtotal,           rsp_vtotal);
               check_field("status",      16'(want.status),      16'(rsp_status));
            end
         end
         if (start && !busy) begin
            if (golden_known)
               expected_lines.push_back(golden_line);
            else
               expected_lines.push_back(correct_mode_line(crtc_mlv_pkg::mode_line_type'({
                  req_raw_hdisp_end, req_raw_hsync_start, req_raw_hsync_end,
                  req_raw_htotal, req_raw_vdisp_end, req_raw_vsync_start,
                  req_raw_vsync_end, req_raw_vtotal})));
         end
      end
   end

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      bit sender_idles;
      reset               = 1'b1;
      start               = 1'b0;
      req_raw_hdisp_end   = '0;
      req_raw_hsync_start = '0;
      req_raw_hsync_end   = '0;
      req_raw_htotal      = '0;
      req_raw_vdisp_end   = '0;
      req_raw_vsync_start = '0;
      req_raw_vsync_end   = '0;
      req_raw_vtotal      = '0;
      golden_known        = 1'b0;
      golden_line         = '0;
      failures            = 0;
      lines_sent          = 0;
      lines_checked       = 0;
      cycle_count         = 0;
      sender_idles        = 1'b0;

      // all zero: display ends, totals and sync starts raised to their floors
      directed_rows[0]  = '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
                            1'b1,
                            '{12'd640, 12'd648, 12'd0, 12'd720,
                              16'd400, 16'd401, 16'd0, 16'd403, crtc_mlv_pkg::STATUS_OK}};
      // all ones: masks and sync end kept below the totals
      directed_rows[1]  = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                            1'b1,
                            '{12'd2040, 12'd4088, 12'd4080, 12'd4088,
                              16'd2047, 16'd4095, 16'd4094, 16'd4095, crtc_mlv_pkg::STATUS_OK}};
      // ordinary line, nothing to correct
      directed_rows[2]  = '{'{16'd640, 16'd656, 16'd752, 16'd800,
                              16'd480, 16'd490, 16'd492, 16'd525}, 1'b0, '0};
      // low horizontal sync start is moved up, not sync end
      directed_rows[3]  = '{'{16'd1024, 16'd100, 16'd1100, 16'd1400,
                              16'd768, 16'd771, 16'd777, 16'd806}, 1'b0, '0};
      // sync end past the total
      directed_rows[4]  = '{'{16'd1280, 16'd1328, 16'd1800, 16'd1688,
                              16'd1024, 16'd1025, 16'd1028, 16'd1066}, 1'b0, '0};
      // horizontal sync too long
      directed_rows[5]  = '{'{16'd800, 16'd840, 16'd1400, 16'd1600,
                              16'd600, 16'd601, 16'd605, 16'd628}, 1'b0, '0};
      // total too short for the blanking margin
      directed_rows[6]  = '{'{16'd1920, 16'd1960, 16'd2000, 16'd1950,
                              16'd1080, 16'd1084, 16'd1089, 16'd1125}, 1'b0, '0};
      // display end below the minimum width
      directed_rows[7]  = '{'{16'd320, 16'd336, 16'd384, 16'd400,
                              16'd240, 16'd245, 16'd247, 16'd262}, 1'b0, '0};
      // unaligned horizontal values
      directed_rows[8]  = '{'{16'h0647, 16'h06A3, 16'h0715, 16'h0839,
                              16'h0401, 16'h0403, 16'h0409, 16'h0421}, 1'b0, '0};
      // vertical height below the minimum
      directed_rows[9]  = '{'{16'd1024, 16'd1048, 16'd1184, 16'd1344,
                              16'd200, 16'd210, 16'd212, 16'd230}, 1'b0, '0};
      // vertical sync too long
      directed_rows[10] = '{'{16'd1024, 16'd1048, 16'd1184, 16'd1344,
                              16'd768, 16'd771, 16'd800, 16'd806}, 1'b0, '0};
      // vertical sync start inside the active area
      directed_rows[11] = '{'{16'd1920, 16'd2008, 16'd2052, 16'd2200,
                              16'd1080, 16'd1000, 16'd1090, 16'd1125}, 1'b0, '0};
      // vertical total short and sync end past it
      directed_rows[12] = '{'{16'd1600, 16'd1664, 16'd1856, 16'd2160,
                              16'd1200, 16'd1201, 16'd1210, 16'd1100}, 1'b0, '0};
      // bits above every mask
      directed_rows[13] = '{'{16'hF280, 16'hE290, 16'hD300, 16'hC320,
                              16'hB1E0, 16'hA1E1, 16'h91E4, 16'h81F4}, 1'b0, '0};
      // alternating bit patterns
      directed_rows[14] = '{'{16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                              16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA}, 1'b0, '0};
      directed_rows[15] = '{'{16'h5555, 16'h5555, 16'h5555, 16'h5555,
                              16'h5555, 16'h5555, 16'h5555, 16'h5555}, 1'b0, '0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, back to back
      foreach (directed_rows[row])
         send_request(directed_rows[row].line, directed_rows[row].golden_known,
                      directed_rows[row].golden);

      // random lines; gaps come and go in stretches of 50, none at the tail
      for (int unsigned n = 0; n < RANDOM_LINES; n++) begin
         if (n % 50 == 0)
            sender_idles = ($urandom_range(0, 2) != 0) && (n < RANDOM_LINES - CALM_TAIL);
         if (n == RANDOM_LINES / 2) begin
            // let the pipeline empty completely once
            hold_off(1);
            while (expected_lines.size() != 0) @(posedge clock);
         end
         send_request(random_mode_line(), 1'b0, '0);
         if (sender_idles && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 9));
      end

      // drain
      start <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_lines.size() != 0) begin
         $error("%0d results never arrived", expected_lines.size());
         failures += expected_lines.size();
      end

      $display("Sent %0d mode lines (%0d from the directed table), checked %0d results,",
               lines_sent, ROW_COUNT, lines_checked);
      $display("with random sender gaps, one full drain mid-run and a gap-free tail.");
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
